>>> rtl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg: shared types and constants for the Modbus RTU response deframer
// Beat structs, frame status codes and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrd_pkg;

    // Default saturation point of the held byte counter
    localparam int COUNT_MAX_DEFAULT = 1023;

    // CRC-16/MODBUS constants
    localparam logic [15:0] CHECK_INIT = 16'hFFFF;
    localparam logic [15:0] CHECK_POLY = 16'hA001;

    // Smallest frame: header of three bytes plus two check bytes
    localparam int MIN_FRAME = 5;
    localparam int HEADER_LEN = 3;

    // Header byte positions
    localparam int POS_DEVICE = 0;
    localparam int POS_FUNCTION = 1;
    localparam int POS_LENGTH = 2;

    // Frame status codes
    localparam logic [1:0] FRAME_INCOMPLETE = 2'd0;
    localparam logic [1:0] FRAME_GOOD       = 2'd1;
    localparam logic [1:0] FRAME_BAD        = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in_beat;

    typedef struct packed {
        logic [9:0]  byte_position;
        logic [1:0]  frame_status;
        logic [7:0]  device_address;
        logic [7:0]  function_code;
        logic [7:0]  payload_length;
        logic        exception_flag;
        logic [15:0] computed_check;
        logic [15:0] received_check;
    } t_out_beat;

    // Fold one byte into the CRC, LSB first, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CHECK_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/mrd_core.sv
// ----------------------------------------------------------------------------
// mrd_core: frame state and per-byte update
// Holds header, running CRC, captured CRC and byte count; forms one result
// per accepted beat from the state after that byte.
// ----------------------------------------------------------------------------
module mrd_core
    import mrd_pkg::*;
#(
    parameter int COUNT_MAX = COUNT_MAX_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_beat  i_beat,
    output t_out_beat o_result
);

    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(COUNT_MAX);

    logic [CW-1:0] r_held, n_held;
    logic [15:0]   r_crc, n_crc;
    logic [15:0]   r_cap, n_cap;
    logic [7:0]    r_dev, n_dev;
    logic [7:0]    r_fun, n_fun;
    logic [7:0]    r_len, n_len;

    logic [CW-1:0] need;
    logic [CW-1:0] held_inc;
    logic [1:0]    status;

    // Update header, CRC and capture for this byte
    always_comb begin
        n_dev = r_dev;
        n_fun = r_fun;
        n_len = r_len;
        n_crc = r_crc;
        n_cap = r_cap;

        if (r_held == CW'(POS_DEVICE)) begin
            n_dev = i_beat.rx_byte;
        end
        if (r_held == CW'(POS_FUNCTION)) begin
            n_fun = i_beat.rx_byte;
        end
        if (r_held == CW'(POS_LENGTH)) begin
            n_len = i_beat.rx_byte;
        end

        need = CW'(HEADER_LEN) + {{(CW-8){1'b0}}, n_len};

        if (r_held < need) begin
            n_crc = crc_byte(r_crc, i_beat.rx_byte);
        end else if (r_held == need) begin
            n_cap = {r_cap[15:8], i_beat.rx_byte};
        end else if (r_held == need + CW'(1)) begin
            n_cap = {i_beat.rx_byte, r_cap[7:0]};
        end

        // Advance the count, saturating
        held_inc = (r_held < CNT_MAX) ? r_held + CW'(1) : r_held;

        // Judge on a chunk end once the whole frame is held
        status = FRAME_INCOMPLETE;
        if (i_beat.chunk_end && held_inc >= CW'(MIN_FRAME) && held_inc >= need + CW'(2)) begin
            status = (n_crc == n_cap) ? FRAME_GOOD : FRAME_BAD;
        end

        o_result.byte_position  = 10'(r_held);
        o_result.frame_status   = status;
        o_result.device_address = n_dev;
        o_result.function_code  = n_fun;
        o_result.payload_length = n_len;
        o_result.exception_flag = n_fun[7];
        o_result.computed_check = n_crc;
        o_result.received_check = n_cap;

        n_held = held_inc;
    end

    // Commit the frame state, or clear it after a judgement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_crc  <= CHECK_INIT;
            r_cap  <= '0;
            r_dev  <= '0;
            r_fun  <= '0;
            r_len  <= '0;
        end else if (i_fire) begin
            if (status != FRAME_INCOMPLETE) begin
                r_held <= '0;
                r_crc  <= CHECK_INIT;
                r_cap  <= '0;
                r_dev  <= '0;
                r_fun  <= '0;
                r_len  <= '0;
            end else begin
                r_held <= n_held;
                r_crc  <= n_crc;
                r_cap  <= n_cap;
                r_dev  <= n_dev;
                r_fun  <= n_fun;
                r_len  <= n_len;
            end
        end
    end

    // A judged frame leaves the state cleared
    a_clear_after_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && status != FRAME_INCOMPLETE) |=> (r_held == '0 && r_crc == CHECK_INIT))
        else $error("frame state not cleared after judgement");

    // A judgement never comes before a minimal frame is held
    a_judge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && status != FRAME_INCOMPLETE) |-> (r_held >= CW'(MIN_FRAME - 1)))
        else $error("frame judged with too few bytes");

    // The counter stays within its saturation point
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_MAX)
        else $error("held count beyond maximum");

    // Without an accepted beat the frame state holds
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_fire && $past(i_rst_n)) |=> ($stable(r_held) && $stable(r_crc)))
        else $error("frame state moved without a beat");

endmodule

>>> rtl/mrd_out_reg.sv
// ----------------------------------------------------------------------------
// mrd_out_reg: result register
// Holds one result beat; takes a new beat in the cycle the held one leaves.
// ----------------------------------------------------------------------------
module mrd_out_reg
    import mrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_beat i_data,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    logic      r_valid;
    t_out_beat r_data;

    // Room when empty or when the held beat is taken now
    assign o_space = !r_valid || i_ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/modbus_rtu_response_deframer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer: Modbus RTU response deframer with CRC check
// Takes received bytes, tracks the response header and CRC-16/MODBUS, and
// reports each byte's frame status.
// ----------------------------------------------------------------------------
// Every accepted byte produces exactly one result beat, in the next cycle, and
// a new byte is taken every cycle while the result register is empty or being
// drained; throughput is one byte per clock, with the unrolled eight-step CRC
// update done combinationally between frame state and result register. A
// chunk end that completes a frame (at least five bytes and header length
// plus five) reports good or bad CRC and clears the frame state; shorter
// chunks report incomplete and the frame carries on in the next chunk.
module modbus_rtu_response_deframer
    import mrd_pkg::*;
#(
    parameter int COUNT_MAX = COUNT_MAX_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    logic      fire;
    logic      space;
    t_out_beat result;

    // Accept a byte whenever the result register has room
    assign o_in_ready = space;
    assign fire       = i_in_valid && space;

    mrd_core #(
        .COUNT_MAX (COUNT_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_beat   (i_in_data),
        .o_result (result)
    );

    mrd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_data  (result),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> tb/tb_modbus_rtu_response_deframer.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_response_deframer: self-checking bench for the response deframer
// Sends Modbus RTU response frames byte by byte (good and bad CRC, frames
// split over several chunks, trailing bytes, noise, truncated frames and one
// long stream that saturates the byte counter). A scoreboard tracks the
// frame state of every accepted byte and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_deframer;
    import mrd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 38;
    localparam int RANDOM_BYTES = 330;
    localparam int STREAM_LEN = COUNT_MAX_DEFAULT + 8;

    // Tracks one frame the way the deframer should and holds the beats it owes
    class frame_checker;
        int          held;
        logic [15:0] crc_acc;
        logic [15:0] crc_rx;
        logic [7:0]  dev;
        logic [7:0]  fn;
        logic [7:0]  len;
        t_out_beat   pending_results[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            errors = 0;
            checked = 0;
            clear_frame();
        endfunction

        // CRC-16/MODBUS, one bit at a time, LSB first
        static function logic [15:0] crc_fold(logic [15:0] acc, logic [7:0] data);
            logic [15:0] c;
            c = acc;
            for (int i = 0; i < 8; i++) begin
                c = (c[0] ^ data[i]) ? ((c >> 1) ^ CHECK_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void clear_frame();
            held = 0;
            crc_acc = CHECK_INIT;
            crc_rx = '0;
            dev = '0;
            fn = '0;
            len = '0;
        endfunction

        // Fold one accepted byte into the frame and queue the beat it causes
        function void note_byte(t_in_beat beat);
            t_out_beat want;
            int        pos;
            int        need;
            pos = held;
            if (pos == POS_DEVICE) begin
                dev = beat.rx_byte;
            end else if (pos == POS_FUNCTION) begin
                fn = beat.rx_byte;
            end else if (pos == POS_LENGTH) begin
                len = beat.rx_byte;
            end
            need = HEADER_LEN + int'(len);
            if (pos < need) begin
                crc_acc = crc_fold(crc_acc, beat.rx_byte);
            end else if (pos == need) begin
                crc_rx[7:0] = beat.rx_byte;
            end else if (pos == need + 1) begin
                crc_rx[15:8] = beat.rx_byte;
            end
            if (held < COUNT_MAX_DEFAULT) begin
                held++;
            end
            want.frame_status = FRAME_INCOMPLETE;
            if (beat.chunk_end && held >= MIN_FRAME && held >= need + 2) begin
                want.frame_status = (crc_acc == crc_rx) ? FRAME_GOOD : FRAME_BAD;
            end
            want.byte_position = 10'(pos);
            want.device_address = dev;
            want.function_code = fn;
            want.payload_length = len;
            want.exception_flag = fn[7];
            want.computed_check = crc_acc;
            want.received_check = crc_rx;
            pending_results.insert(pending_results.size(), want);
            // A judged frame starts over from the reset state
            if (want.frame_status != FRAME_INCOMPLETE) begin
                clear_frame();
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, field, want, seen);
                errors++;
            end
        endfunction

        // Match a result beat against the oldest owed beat
        function void check_beat(t_out_beat got);
            t_out_beat want;
            checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual 0x%0h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("byte_position", 32'(want.byte_position), 32'(got.byte_position));
            compare("frame_status", 32'(want.frame_status), 32'(got.frame_status));
            compare("device_address", 32'(want.device_address),
                    32'(got.device_address));
            compare("function_code", 32'(want.function_code), 32'(got.function_code));
            compare("payload_length", 32'(want.payload_length),
                    32'(got.payload_length));
            compare("exception_flag", 32'(want.exception_flag),
                    32'(got.exception_flag));
            compare("computed_check", 32'(want.computed_check),
                    32'(got.computed_check));
            compare("received_check", 32'(want.received_check),
                    32'(got.received_check));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    frame_checker sb = new();
    int unsigned  bytes_sent = 0;
    int unsigned  send_idle_pct = IDLE_PCT;

    modbus_rtu_response_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offer one byte, idling at random first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_beat beat;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        beat.rx_byte = b;
        beat.chunk_end = last;
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(i_in_data);
        bytes_sent++;
    endtask

    // Hold off the sender until every owed beat has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    // Close out whatever partial frame the deframer holds
    task automatic flush_partial();
        while (sb.held != 0) begin
            send_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    // Send one response frame; keep < 0 sends it whole, else only the first bytes
    task automatic send_frame(input logic [7:0] dev, input logic [7:0] fn,
                              input logic [7:0] len, input bit good,
                              input int n_extra, input int split_at,
                              input int split_pct, input int keep);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        int          count;
        logic        last;
        frame_bytes = {dev, fn, len};
        for (int i = 0; i < int'(len); i++) begin
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
        end
        crc = CHECK_INIT;
        foreach (frame_bytes[i]) begin
            crc = frame_checker::crc_fold(crc, frame_bytes[i]);
        end
        if (!good) begin
            crc ^= 16'($urandom_range(65535, 1));
        end
        frame_bytes.insert(frame_bytes.size(), crc[7:0]);
        frame_bytes.insert(frame_bytes.size(), crc[15:8]);
        repeat (n_extra) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
        count = (keep < 0) ? frame_bytes.size() : keep;
        // Chunk ends before the last check byte never complete the frame
        for (int i = 0; i < count; i++) begin
            last = (i == count - 1) || (i == split_at) ||
                   (i < 4 + int'(len) && $urandom_range(99) < split_pct);
            send_byte(frame_bytes[i], last);
        end
    endtask

    function automatic logic [7:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 1) begin
            return 8'd255;
        end else if (r < 4) begin
            return 8'($urandom_range(254, 9));
        end
        return 8'($urandom_range(8, 0));
    endfunction

    // Drain result beats with random backpressure, one long hold-off and a stretch of constant readiness
    initial begin : result_sink
        int unsigned stall_left;
        bit          stalled_once;
        stall_left = 0;
        stalled_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_beat(o_out_data);
            end
            if (!stalled_once && sb.checked == 400) begin
                stall_left = 120;
                stalled_once = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (sb.checked >= 1200 && sb.checked < 1600) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Bound the run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("%0t: timed out with %0d beats owed", $time,
                         sb.pending_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned rand_start;
        int unsigned iter;
        int unsigned r;
        iter = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame, good CRC, extreme header bytes
        send_frame(8'hFF, 8'h00, 8'd0, 1'b1, 0, -1, 0, -1);
        // Smallest frame, bad CRC, exception response
        send_frame(8'h00, 8'hFF, 8'd0, 1'b0, 0, -1, 0, -1);
        // Chunk end on the last header byte, then trailing bytes dropped at the end
        send_frame(8'h11, 8'h03, 8'd2, 1'b1, 2, 2, 0, -1);
        // Chunk end with five bytes held but fewer than length plus five
        send_frame(8'h01, 8'h83, 8'd1, 1'b1, 0, 4, 0, -1);
        drain_results();

        // Longest payload, then a stream that saturates the counter
        send_frame(8'($urandom_range(255)), 8'h04, 8'd255, 1'b1, 0, -1, 2, -1);
        for (int i = 0; i < STREAM_LEN; i++) begin
            send_byte(8'($urandom_range(255)), i == STREAM_LEN - 1);
        end
        flush_partial();

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES) begin
            send_idle_pct = (iter >= 10 && iter < 30) ? 0 : IDLE_PCT;
            r = $urandom_range(99);
            if (r < 72) begin
                flush_partial();
                send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                           pick_length(), $urandom_range(99) < 75,
                           ($urandom_range(99) < 20) ? $urandom_range(4, 1) : 0,
                           -1, 15, -1);
            end else if (r < 84) begin
                repeat ($urandom_range(12, 1)) begin
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
                end
            end else if (r < 96) begin
                flush_partial();
                begin
                    logic [7:0] cut_len;
                    cut_len = pick_length();
                    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                               cut_len, 1'b1, 0, -1, 15,
                               $urandom_range(4 + int'(cut_len), 1));
                end
            end else begin
                drain_results();
            end
            iter++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
